>>> design/atc_pkg.sv
package atc_pkg;

    localparam int WINDOW_DEF       = 8;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int TAB_LEN          = 24;
    localparam int ISQ_W            = 64;
    localparam logic [31:0] ANG_QUARTER = 32'h4000_0000;

    typedef enum logic {
        F_IDLE,
        F_UPD
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SQ,
        B_SUM,
        B_ROOT,
        B_TILT,
        B_DONE
    } back_state_t;

    function automatic logic [31:0] step_angle(input logic [4:0] idx);
        logic [31:0] a;
        case (idx)
            5'd0:    a = 32'h20000000;
            5'd1:    a = 32'h12E4051E;
            5'd2:    a = 32'h09FB385B;
            5'd3:    a = 32'h051111D4;
            5'd4:    a = 32'h028B0D43;
            5'd5:    a = 32'h0145D7E1;
            5'd6:    a = 32'h00A2F61E;
            5'd7:    a = 32'h00517C55;
            5'd8:    a = 32'h0028BE53;
            5'd9:    a = 32'h00145F2F;
            5'd10:   a = 32'h000A2F98;
            5'd11:   a = 32'h000517CC;
            5'd12:   a = 32'h00028BE6;
            5'd13:   a = 32'h000145F3;
            5'd14:   a = 32'h0000A2F9;
            5'd15:   a = 32'h0000517C;
            5'd16:   a = 32'h000028BE;
            5'd17:   a = 32'h0000145F;
            5'd18:   a = 32'h00000A2F;
            5'd19:   a = 32'h00000517;
            5'd20:   a = 32'h0000028B;
            5'd21:   a = 32'h00000145;
            5'd22:   a = 32'h000000A2;
            5'd23:   a = 32'h00000051;
            default: a = 32'h00000000;
        endcase
        return a;
    endfunction

endpackage

>>> design/atc_front.sv
module atc_front #(
    parameter int WINDOW = atc_pkg::WINDOW_DEF,
    parameter int SUM_W  = 16 + $clog2(WINDOW)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_accel_x,
    input  logic signed [15:0] s_accel_y,
    input  logic signed [15:0] s_accel_z,
    output logic               push,
    input  logic               full,
    output logic [3*SUM_W-1:0] push_data
);
    localparam int WPW = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    atc_pkg::front_state_t state_reg, state_next;
    logic [47:0]       mem [WINDOW];
    logic [47:0]       rd_reg;
    logic [47:0]       smp_reg;
    logic [WPW-1:0]    wp_reg, wp_next;
    logic              wrap_reg, wrap_next;
    logic signed [SUM_W-1:0] sx_reg, sy_reg, sz_reg, sx_next, sy_next, sz_next;
    logic signed [SUM_W-1:0] ox, oy, oz;
    logic              accept;

    assign s_ready = (state_reg == atc_pkg::F_IDLE);
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_reg  <= mem[wp_reg];
            smp_reg <= {s_accel_x, s_accel_y, s_accel_z};
        end
        if (push) begin
            mem[wp_reg] <= smp_reg;
        end
    end

    always_comb begin
        state_next = state_reg;
        wp_next    = wp_reg;
        wrap_next  = wrap_reg;
        sx_next    = sx_reg;
        sy_next    = sy_reg;
        sz_next    = sz_reg;
        push       = 1'b0;
        ox = wrap_reg ? SUM_W'($signed(rd_reg[47:32])) : '0;
        oy = wrap_reg ? SUM_W'($signed(rd_reg[31:16])) : '0;
        oz = wrap_reg ? SUM_W'($signed(rd_reg[15:0]))  : '0;
        case (state_reg)
            atc_pkg::F_IDLE: begin
                if (accept) begin
                    state_next = atc_pkg::F_UPD;
                end
            end
            atc_pkg::F_UPD: begin
                if (!full) begin
                    push    = 1'b1;
                    sx_next = sx_reg + SUM_W'($signed(smp_reg[47:32])) - ox;
                    sy_next = sy_reg + SUM_W'($signed(smp_reg[31:16])) - oy;
                    sz_next = sz_reg + SUM_W'($signed(smp_reg[15:0]))  - oz;
                    if (wp_reg == WPW'(WINDOW - 1)) begin
                        wp_next   = '0;
                        wrap_next = 1'b1;
                    end else begin
                        wp_next = wp_reg + 1'b1;
                    end
                    state_next = atc_pkg::F_IDLE;
                end
            end
            default: state_next = atc_pkg::F_IDLE;
        endcase
    end

    assign push_data = {sx_next, sy_next, sz_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= atc_pkg::F_IDLE;
            wp_reg    <= '0;
            wrap_reg  <= 1'b0;
            sx_reg    <= '0;
            sy_reg    <= '0;
            sz_reg    <= '0;
        end else begin
            state_reg <= state_next;
            wp_reg    <= wp_next;
            wrap_reg  <= wrap_next;
            sx_reg    <= sx_next;
            sy_reg    <= sy_next;
            sz_reg    <= sz_next;
        end
    end
endmodule

>>> design/atc_fifo.sv
module atc_fifo #(
    parameter int DW = 57
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  logic [DW-1:0] push_data,
    output logic          full,
    input  logic          pop,
    output logic          empty,
    output logic [DW-1:0] pop_data
);
    logic [DW-1:0] q_reg [2];
    logic          wr_reg, rd_reg;
    logic [1:0]    cnt_reg;

    assign full     = (cnt_reg == 2'd2);
    assign empty    = (cnt_reg == 2'd0);
    assign pop_data = q_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (push && !full) begin
            q_reg[wr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push && !full) begin
                wr_reg <= ~wr_reg;
            end
            if (pop && !empty) begin
                rd_reg <= ~rd_reg;
            end
            cnt_reg <= cnt_reg + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full)) else $error("push into full queue");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && empty)) else $error("pop from empty queue");
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3) else $error("queue count out of range");
    a_ptr_match: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd0 || cnt_reg == 2'd2) |-> (wr_reg == rd_reg))
        else $error("queue pointers disagree with count");
endmodule

>>> design/atc_cordic.sv
module atc_cordic #(
    parameter int CW    = 35,
    parameter int STEPS = atc_pkg::CORDIC_STEPS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic signed [CW-1:0] y_in,
    input  logic signed [CW-1:0] x_in,
    output logic                 busy,
    output logic [15:0]          angle
);
    localparam int NSTEP = (STEPS > atc_pkg::TAB_LEN) ? atc_pkg::TAB_LEN : STEPS;
    localparam int IW    = $clog2(NSTEP);

    logic signed [CW-1:0] x_reg, x_next, y_reg, y_next, dx, dy;
    logic [31:0]          acc_reg, acc_next, rnd;
    logic [IW-1:0]        idx_reg, idx_next;
    logic                 run_reg, run_next, zero_reg, zero_next;

    always_comb begin
        x_next    = x_reg;
        y_next    = y_reg;
        acc_next  = acc_reg;
        idx_next  = idx_reg;
        run_next  = run_reg;
        zero_next = zero_reg;
        dx = x_reg >>> idx_reg;
        dy = y_reg >>> idx_reg;
        if (start) begin
            zero_next = (x_in == '0) && (y_in == '0);
            run_next  = 1'b1;
            idx_next  = '0;
            if (x_in < 0) begin
                if (y_in >= 0) begin
                    x_next   = y_in;
                    y_next   = -x_in;
                    acc_next = atc_pkg::ANG_QUARTER;
                end else begin
                    x_next   = -y_in;
                    y_next   = x_in;
                    acc_next = -atc_pkg::ANG_QUARTER;
                end
            end else begin
                x_next   = x_in;
                y_next   = y_in;
                acc_next = '0;
            end
        end else if (run_reg) begin
            if (y_reg >= 0) begin
                x_next   = x_reg + dy;
                y_next   = y_reg - dx;
                acc_next = acc_reg + atc_pkg::step_angle(5'(idx_reg));
            end else begin
                x_next   = x_reg - dy;
                y_next   = y_reg + dx;
                acc_next = acc_reg - atc_pkg::step_angle(5'(idx_reg));
            end
            if (idx_reg == IW'(NSTEP - 1)) begin
                run_next = 1'b0;
            end else begin
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    assign busy  = run_reg;
    assign rnd   = acc_reg + 32'h0000_8000;
    assign angle = zero_reg ? 16'd0 : rnd[31:16];

    always_ff @(posedge aclk) begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        acc_reg  <= acc_next;
        idx_reg  <= idx_next;
        zero_reg <= zero_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= 1'b0;
        end else begin
            run_reg <= run_next;
        end
    end
endmodule

>>> design/atc_back.sv
module atc_back #(
    parameter int WINDOW       = atc_pkg::WINDOW_DEF,
    parameter int CORDIC_STEPS = atc_pkg::CORDIC_STEPS_DEF,
    parameter int SUM_W        = 16 + $clog2(WINDOW)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               empty,
    output logic               pop,
    input  logic [3*SUM_W-1:0] pop_data,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_mean_x,
    output logic signed [15:0] m_mean_y,
    output logic signed [15:0] m_mean_z,
    output logic signed [15:0] m_tilt_x,
    output logic signed [15:0] m_tilt_y,
    output logic [7:0]         m_servo_x,
    output logic [7:0]         m_servo_y
);
    localparam int CW = SUM_W + 11;
    localparam int MK = SUM_W + $clog2(WINDOW);
    localparam logic [MK:0] MR = (MK + 1)'(((64'd1 << MK) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));
    localparam int PW = SUM_W + MK + 1;
    localparam int QW = 2 * SUM_W;

    atc_pkg::back_state_t state_reg, state_next;
    logic signed [SUM_W-1:0] sx_reg, sy_reg, sz_reg;
    logic [QW-1:0]           sqy_reg, sqz_reg;
    logic [15:0]             mx_reg, my_reg, mz_reg;
    logic [atc_pkg::ISQ_W-1:0] n_reg, n_next, res_reg, res_next, one, trial;
    logic [4:0]              bit_reg, bit_next;
    logic                    start_a, start_b, busy_a, busy_b;
    logic [15:0]             ang_a, ang_b, tx;
    logic signed [CW-1:0]    ya, xa, yb, xb;
    logic signed [25:0]      num_x, num_y;
    logic [7:0]              srv_x, srv_y;
    logic                    load_out;
    logic                    m_valid_reg;
    logic [15:0]             omx_reg, omy_reg, omz_reg, otx_reg, oty_reg;
    logic [7:0]              osx_reg, osy_reg;

    function automatic logic [15:0] mean16(input logic signed [SUM_W-1:0] s);
        logic [SUM_W-1:0] m;
        logic [PW-1:0]    p;
        logic [15:0]      q;
        m = (s < 0) ? SUM_W'(-s) : SUM_W'(s);
        m = m + SUM_W'(WINDOW / 2);
        p = PW'(m) * PW'(MR);
        q = 16'(p >> MK);
        return (s < 0) ? 16'(-q) : q;
    endfunction

    function automatic logic [7:0] servo(input logic signed [25:0] num);
        logic signed [25:0] q;
        logic [7:0]         r;
        q = num >>> 15;
        if (num < 0) begin
            r = 8'd0;
        end else if (q > 26'sd180) begin
            r = 8'd180;
        end else begin
            r = 8'(q);
        end
        return r;
    endfunction

    assign ya = CW'(sy_reg) <<< 8;
    assign xa = CW'(sz_reg) <<< 8;
    assign yb = CW'(sx_reg) <<< 8;
    assign xb = CW'($signed({1'b0, res_reg[CW-2:0]}));

    atc_cordic #(.CW(CW), .STEPS(CORDIC_STEPS)) u_cordic_a (
        .aclk(aclk), .aresetn(aresetn), .start(start_a),
        .y_in(ya), .x_in(xa), .busy(busy_a), .angle(ang_a)
    );

    atc_cordic #(.CW(CW), .STEPS(CORDIC_STEPS)) u_cordic_b (
        .aclk(aclk), .aresetn(aresetn), .start(start_b),
        .y_in(yb), .x_in(xb), .busy(busy_b), .angle(ang_b)
    );

    assign one   = atc_pkg::ISQ_W'(1) << {bit_reg, 1'b0};
    assign trial = res_reg + one;
    assign tx    = 16'd0 - ang_a;
    assign num_x = 26'($signed(tx)) * 26'sd180 + 26'sd2949120;
    assign num_y = 26'($signed(ang_b)) * 26'sd360 + 26'sd5898240;
    assign srv_x = servo(num_x);
    assign srv_y = servo(num_y);

    always_comb begin
        state_next = state_reg;
        n_next     = n_reg;
        res_next   = res_reg;
        bit_next   = bit_reg;
        pop        = 1'b0;
        start_a    = 1'b0;
        start_b    = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            atc_pkg::B_IDLE: begin
                if (!empty) begin
                    pop        = 1'b1;
                    state_next = atc_pkg::B_SQ;
                end
            end
            atc_pkg::B_SQ: begin
                start_a    = 1'b1;
                state_next = atc_pkg::B_SUM;
            end
            atc_pkg::B_SUM: begin
                n_next     = atc_pkg::ISQ_W'({sqy_reg + sqz_reg, 16'd0});
                res_next   = '0;
                bit_next   = 5'd31;
                state_next = atc_pkg::B_ROOT;
            end
            atc_pkg::B_ROOT: begin
                if (n_reg >= trial) begin
                    n_next   = n_reg - trial;
                    res_next = (res_reg >> 1) + one;
                end else begin
                    res_next = res_reg >> 1;
                end
                if (bit_reg == 5'd0) begin
                    state_next = atc_pkg::B_TILT;
                end else begin
                    bit_next = bit_reg - 1'b1;
                end
            end
            atc_pkg::B_TILT: begin
                start_b    = 1'b1;
                state_next = atc_pkg::B_DONE;
            end
            atc_pkg::B_DONE: begin
                if (!busy_a && !busy_b && (!m_valid_reg || m_ready)) begin
                    load_out   = 1'b1;
                    state_next = atc_pkg::B_IDLE;
                end
            end
            default: state_next = atc_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            sx_reg <= pop_data[3*SUM_W-1:2*SUM_W];
            sy_reg <= pop_data[2*SUM_W-1:SUM_W];
            sz_reg <= pop_data[SUM_W-1:0];
        end
        if (state_reg == atc_pkg::B_SQ) begin
            sqy_reg <= QW'(sy_reg * sy_reg);
            sqz_reg <= QW'(sz_reg * sz_reg);
            mx_reg  <= mean16(sx_reg);
            my_reg  <= mean16(sy_reg);
            mz_reg  <= mean16(sz_reg);
        end
        n_reg   <= n_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
        if (load_out) begin
            omx_reg <= mx_reg;
            omy_reg <= my_reg;
            omz_reg <= mz_reg;
            otx_reg <= tx;
            oty_reg <= ang_b;
            osx_reg <= srv_x;
            osy_reg <= srv_y;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= atc_pkg::B_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_mean_x  = omx_reg;
    assign m_mean_y  = omy_reg;
    assign m_mean_z  = omz_reg;
    assign m_tilt_x  = otx_reg;
    assign m_tilt_y  = oty_reg;
    assign m_servo_x = osx_reg;
    assign m_servo_y = osy_reg;

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |-> (!m_valid_reg || m_ready)) else $error("result overwritten");
    a_cordic_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |-> (!busy_a && !busy_b)) else $error("angle taken while busy");
    a_pop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (state_reg == atc_pkg::B_IDLE)) else $error("pop while busy");
endmodule

>>> design/accel_tilt_smoother.sv
// accel_tilt_smoother: windowed three-axis accelerometer smoother with tilt angles
// input channel: s_valid/s_ready with s_accel_x/y/z, one raw sample per beat
// result channel: m_valid/m_ready with mean_x/y/z, tilt_x/y and servo_x/y,
//   exactly one result beat per input beat, in order
// the front takes a beat, reads the old window slot and updates the running
//   sums, then queues the sums (two entries) for the back
// the back computes rounded means, an iterative integer square root (one
//   result bit per cycle) and two iterative angle units; the second angle
//   waits for the root
// the back handles one queued beat at a time and pops the next only after
//   loading the result; sustained throughput is set by the square root
//   followed by the second angle unit
// reset clears the sums, the write position and the window fill flag, so the
//   window reads as zeros during warm-up; no clearing pass is needed
// when the receiver stalls, the result waits in the output register while the
//   back, the queue and the front take up to four more beats before s_ready drops
module accel_tilt_smoother #(
    parameter int WINDOW       = atc_pkg::WINDOW_DEF,
    parameter int CORDIC_STEPS = atc_pkg::CORDIC_STEPS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_accel_x,
    input  logic signed [15:0] s_accel_y,
    input  logic signed [15:0] s_accel_z,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_mean_x,
    output logic signed [15:0] m_mean_y,
    output logic signed [15:0] m_mean_z,
    output logic signed [15:0] m_tilt_x,
    output logic signed [15:0] m_tilt_y,
    output logic [7:0]         m_servo_x,
    output logic [7:0]         m_servo_y
);
    localparam int SUM_W = 16 + $clog2(WINDOW);

    logic               push, full, pop, empty;
    logic [3*SUM_W-1:0] push_data, pop_data;

    atc_front #(.WINDOW(WINDOW), .SUM_W(SUM_W)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_accel_x(s_accel_x), .s_accel_y(s_accel_y), .s_accel_z(s_accel_z),
        .push(push), .full(full), .push_data(push_data)
    );

    atc_fifo #(.DW(3 * SUM_W)) u_fifo (
        .aclk(aclk), .aresetn(aresetn),
        .push(push), .push_data(push_data), .full(full),
        .pop(pop), .empty(empty), .pop_data(pop_data)
    );

    atc_back #(.WINDOW(WINDOW), .CORDIC_STEPS(CORDIC_STEPS), .SUM_W(SUM_W)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .empty(empty), .pop(pop), .pop_data(pop_data),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_mean_x(m_mean_x), .m_mean_y(m_mean_y), .m_mean_z(m_mean_z),
        .m_tilt_x(m_tilt_x), .m_tilt_y(m_tilt_y),
        .m_servo_x(m_servo_x), .m_servo_y(m_servo_y)
    );
endmodule

>>> verif/accel_tilt_smoother_test.sv
module accel_tilt_smoother_test;

    localparam int WIN   = atc_pkg::WINDOW_DEF;
    localparam int STEPS = atc_pkg::CORDIC_STEPS_DEF;

    typedef struct packed {
        logic signed [15:0] mean_x, mean_y, mean_z, tilt_x, tilt_y;
        logic [7:0]         servo_x, servo_y;
    } tilt_res_t;

    class tilt_scoreboard;
        logic signed [15:0] win_x[WIN], win_y[WIN], win_z[WIN];
        longint sum_x, sum_y, sum_z;
        int pos;
        tilt_res_t pending[$];
        int errors;

        function new();
            for (int i = 0; i < WIN; i++) begin
                win_x[i] = 0;
                win_y[i] = 0;
                win_z[i] = 0;
            end
            sum_x = 0;
            sum_y = 0;
            sum_z = 0;
            pos = 0;
            errors = 0;
        endfunction

        function longint floor_shr(longint v, int s);
            return v >>> s;
        endfunction

        function longint unsigned int_sqrt(longint unsigned n);
            longint unsigned r, one;
            r = 0;
            one = 64'd1 << 62;
            while (one > n) one >>= 2;
            while (one != 0) begin
                if (n >= r + one) begin
                    n -= r + one;
                    r = (r >> 1) + one;
                end else begin
                    r >>= 1;
                end
                one >>= 2;
            end
            return r;
        endfunction

        function logic [15:0] binary_angle(longint y, longint x);
            longint acc, t, dx, dy;
            logic [31:0] a;
            acc = 0;
            if (x == 0 && y == 0) return 16'd0;
            if (x < 0) begin
                t = x;
                if (y >= 0) begin
                    x = y;
                    y = -t;
                    acc = 64'sd1073741824;
                end else begin
                    x = -y;
                    y = t;
                    acc = -64'sd1073741824;
                end
            end
            for (int i = 0; i < (STEPS > atc_pkg::TAB_LEN ? atc_pkg::TAB_LEN : STEPS); i++) begin
                dx = floor_shr(x, i);
                dy = floor_shr(y, i);
                if (y >= 0) begin
                    x += dy;
                    y -= dx;
                    acc += longint'(atc_pkg::step_angle(5'(i)));
                end else begin
                    x -= dy;
                    y += dx;
                    acc -= longint'(atc_pkg::step_angle(5'(i)));
                end
            end
            a = 32'(acc) + 32'h8000;
            return a[31:16];
        endfunction

        function logic [7:0] servo_cmd(longint num);
            longint q;
            if (num < 0) return 8'd0;
            q = num >>> 15;
            return q > 180 ? 8'd180 : 8'(q);
        endfunction

        function logic [15:0] rounded_mean(longint s);
            longint m;
            m = s >= 0 ? (s + WIN / 2) / WIN : -((-s + WIN / 2) / WIN);
            return 16'(m);
        endfunction

        function void note_sample(logic signed [15:0] x, logic signed [15:0] y,
                                  logic signed [15:0] z);
            tilt_res_t r;
            longint unsigned mag2;
            longint mag;
            sum_x += longint'(x) - longint'(win_x[pos]);
            sum_y += longint'(y) - longint'(win_y[pos]);
            sum_z += longint'(z) - longint'(win_z[pos]);
            win_x[pos] = x;
            win_y[pos] = y;
            win_z[pos] = z;
            pos = (pos + 1 >= WIN) ? 0 : pos + 1;
            mag2 = longint'(sum_y * sum_y) + longint'(sum_z * sum_z);
            mag = longint'(int_sqrt(mag2 << 16));
            r.mean_x = rounded_mean(sum_x);
            r.mean_y = rounded_mean(sum_y);
            r.mean_z = rounded_mean(sum_z);
            r.tilt_x = 16'(16'd0 - binary_angle(sum_y * 256, sum_z * 256));
            r.tilt_y = binary_angle(sum_x * 256, mag);
            r.servo_x = servo_cmd(longint'(r.tilt_x) * 180 + 90 * 32768);
            r.servo_y = servo_cmd(longint'(r.tilt_y) * 360 + 180 * 32768);
            pending.push_back(r);
        endfunction

        function void check_result(tilt_res_t got);
            tilt_res_t e;
            if (pending.size() == 0) begin
                $display("%0t unexpected result beat", $realtime);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.mean_x !== e.mean_x)
                $display("%0t mean_x exp %0d got %0d", $realtime, e.mean_x, got.mean_x);
            if (got.mean_y !== e.mean_y)
                $display("%0t mean_y exp %0d got %0d", $realtime, e.mean_y, got.mean_y);
            if (got.mean_z !== e.mean_z)
                $display("%0t mean_z exp %0d got %0d", $realtime, e.mean_z, got.mean_z);
            if (got.tilt_x !== e.tilt_x)
                $display("%0t tilt_x exp %0d got %0d", $realtime, e.tilt_x, got.tilt_x);
            if (got.tilt_y !== e.tilt_y)
                $display("%0t tilt_y exp %0d got %0d", $realtime, e.tilt_y, got.tilt_y);
            if (got.servo_x !== e.servo_x)
                $display("%0t servo_x exp %0d got %0d", $realtime, e.servo_x, got.servo_x);
            if (got.servo_y !== e.servo_y)
                $display("%0t servo_y exp %0d got %0d", $realtime, e.servo_y, got.servo_y);
            if (got !== e) errors++;
        endfunction
    endclass

    logic               aclk = 0;
    logic               aresetn = 0;
    logic               s_valid = 0;
    logic               s_ready;
    logic signed [15:0] s_accel_x = 0, s_accel_y = 0, s_accel_z = 0;
    logic               m_valid;
    logic               m_ready = 0;
    logic signed [15:0] m_mean_x, m_mean_y, m_mean_z, m_tilt_x, m_tilt_y;
    logic [7:0]         m_servo_x, m_servo_y;

    tilt_scoreboard sb = new();
    bit  src_done = 0;
    bit  calm = 0;
    int  hold_off = 0;

    accel_tilt_smoother i_dut (.*);

    always #5 aclk = ~aclk;

    task automatic send_sample(logic [15:0] x, logic [15:0] y, logic [15:0] z);
        while (!calm && $urandom_range(99) < 33) begin
            s_valid <= 0;
            @(posedge aclk);
        end
        s_valid   <= 1;
        s_accel_x <= x;
        s_accel_y <= y;
        s_accel_z <= z;
        do @(posedge aclk); while (!s_ready);
        sb.note_sample(x, y, z);
    endtask

    function automatic logic [15:0] rand_axis();
        case ($urandom_range(5))
            0:       return 16'($urandom);
            1:       return $urandom_range(1) ? 16'h8000 : 16'h7fff;
            2:       return 16'($signed(16'($urandom_range(64))) - 32);
            3:       return $urandom_range(1) ? 16'd16384 : 16'hc000;
            default: return 16'($signed(16'($urandom_range(32768))) - 16384);
        endcase
    endfunction

    // sender
    initial begin
        logic [15:0] ext[4];
        ext = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};
        repeat (11) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        send_sample(0, 0, 0);
        send_sample(0, 0, 16'hc000);
        send_sample(0, 0, 16'hc000);
        for (int i = 0; i < 16; i++)
            send_sample(ext[i % 4], ext[(i / 4) % 4], ext[(i + 1) % 4]);
        for (int i = 0; i < 8; i++) send_sample(16'h8000, 0, 16'h8000);
        for (int i = 0; i < 8; i++) send_sample(16'h7fff, 0, 16'h7fff);
        for (int i = 0; i < 550; i++) begin
            calm = (i >= 200 && i < 280);
            if (i == 350) hold_off = 400;
            send_sample(rand_axis(), rand_axis(), rand_axis());
        end
        s_valid <= 0;
        calm = 0;
        src_done = 1;
    end

    // receiver
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result('{m_mean_x, m_mean_y, m_mean_z, m_tilt_x, m_tilt_y,
                              m_servo_x, m_servo_y});
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_ready  <= 0;
        end else begin
            m_ready <= calm || ($urandom_range(99) >= 33);
        end
    end

    initial begin
        wait (src_done);
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("status: fail");
        $finish;
    end
endmodule
